[src/kops_pkg.sv]
// Shared types, constants and tables for the Kepler orbit position solver.
package kops_pkg;

  typedef logic signed [35:0] dp_t;

  localparam logic [31:0] HALF_TURN     = 32'h8000_0000;
  localparam dp_t         CORDIC_GAIN   = 36'sh0_26DD_3B6A;
  localparam dp_t         TURNS_PER_RAD = 36'sd683565276;
  localparam logic [4:0]  CORDIC_LAST   = 5'd30;

  localparam logic MODE_ROTATE = 1'b0;
  localparam logic MODE_VECTOR = 1'b1;

  localparam logic [20:0] THRESH_MAX = 21'd1048576;
  localparam logic [6:0]  LIMIT_MAX  = 7'd64;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOCONV = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;
  localparam logic [1:0] ST_CLAMP  = 2'd3;

  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  function automatic logic [29:0] cordic_atan(input logic [4:0] idx);
    logic [29:0] a;
    case (idx)
      5'd0:  a = 30'h20000000;
      5'd1:  a = 30'h12E4051E;
      5'd2:  a = 30'h09FB385B;
      5'd3:  a = 30'h051111D4;
      5'd4:  a = 30'h028B0D43;
      5'd5:  a = 30'h0145D7E1;
      5'd6:  a = 30'h00A2F61E;
      5'd7:  a = 30'h00517C55;
      5'd8:  a = 30'h0028BE53;
      5'd9:  a = 30'h00145F2F;
      5'd10: a = 30'h000A2F98;
      5'd11: a = 30'h000517CC;
      5'd12: a = 30'h00028BE6;
      5'd13: a = 30'h000145F3;
      5'd14: a = 30'h0000A2FA;
      5'd15: a = 30'h0000517D;
      5'd16: a = 30'h000028BE;
      5'd17: a = 30'h0000145F;
      5'd18: a = 30'h00000A30;
      5'd19: a = 30'h00000518;
      5'd20: a = 30'h0000028C;
      5'd21: a = 30'h00000146;
      5'd22: a = 30'h000000A3;
      5'd23: a = 30'h00000051;
      5'd24: a = 30'h00000029;
      5'd25: a = 30'h00000014;
      5'd26: a = 30'h0000000A;
      5'd27: a = 30'h00000005;
      5'd28: a = 30'h00000003;
      5'd29: a = 30'h00000001;
      5'd30: a = 30'h00000001;
      default: a = 30'h0;
    endcase
    return a;
  endfunction

endpackage

[src/kops_cordic.sv]
// Iterative CORDIC: rotation gives cosine and sine, vectoring gives a four-quadrant angle.
module kops_cordic (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             mode,
  input  kops_pkg::dp_t    x_in,
  input  kops_pkg::dp_t    y_in,
  input  logic [31:0]      t_in,
  output logic             busy,
  output kops_pkg::dp_t    x_out,
  output kops_pkg::dp_t    y_out,
  output logic [31:0]      ang_out
);

  logic                busy_r;
  logic [4:0]          step_r;
  logic                mode_r;
  logic                flip_r;
  logic                zero_r;
  kops_pkg::dp_t       x_r;
  kops_pkg::dp_t       y_r;
  logic signed [33:0]  z_r;
  logic [31:0]         off_r;
  logic                flip;
  logic [31:0]         tt;
  logic                up;
  kops_pkg::dp_t       xs;
  kops_pkg::dp_t       ys;
  logic signed [33:0]  a;

  assign flip = t_in[31] ^ t_in[30];
  assign tt   = flip ? (t_in ^ kops_pkg::HALF_TURN) : t_in;
  assign xs   = x_r >>> step_r;
  assign ys   = y_r >>> step_r;
  assign a    = $signed({4'b0, kops_pkg::cordic_atan(step_r)});
  assign up   = (mode_r == kops_pkg::MODE_ROTATE) ? !z_r[33] : !(y_r > 36'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == kops_pkg::CORDIC_LAST) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode;
      if (mode == kops_pkg::MODE_ROTATE) begin
        flip_r <= flip;
        zero_r <= 1'b0;
        off_r  <= '0;
        x_r    <= kops_pkg::CORDIC_GAIN;
        y_r    <= '0;
        z_r    <= $signed({{2{tt[31]}}, tt});
      end else begin
        flip_r <= 1'b0;
        zero_r <= (x_in == '0) && (y_in == '0);
        z_r    <= '0;
        if (x_in < 36'sd0) begin
          x_r   <= -x_in;
          y_r   <= -y_in;
          off_r <= kops_pkg::HALF_TURN;
        end else begin
          x_r   <= x_in;
          y_r   <= y_in;
          off_r <= '0;
        end
      end
    end else if (busy_r) begin
      if (up) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - a;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + a;
      end
    end
  end

  assign busy    = busy_r;
  assign x_out   = flip_r ? -x_r : x_r;
  assign y_out   = flip_r ? -y_r : y_r;
  assign ang_out = zero_r ? 32'd0 : (off_r + z_r[31:0]);

endmodule

[src/kops_div.sv]
// Restoring divider, one quotient bit per cycle.
module kops_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [34:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [63:0] q_r;
  logic [34:0] rem_r;
  logic [34:0] dsr_r;
  logic [35:0] rem_sh;
  logic [35:0] diff;
  logic        ge;

  assign rem_sh = {rem_r, q_r[63]};
  assign ge     = rem_sh >= {1'b0, dsr_r};
  assign diff   = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[34:0] : rem_sh[34:0];
      q_r   <= {q_r[62:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

[src/kops_sqrt.sv]
// Bit-serial integer square root, two radicand bits per cycle.
module kops_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] n_in,
  output logic        busy,
  output logic [31:0] root
);

  logic        busy_r;
  logic [63:0] n_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] sum;
  logic        ge;

  assign sum = res_r + bit_r;
  assign ge  = n_r >= sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= n_in;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      n_r   <= ge ? (n_r - sum) : n_r;
      res_r <= ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = res_r[31:0];

endmodule

[src/kepler_orbit_position_solver.sv]
// Top level: sequencer, shared multiplier, registers and handshakes of the orbit solver.
// Each item takes from 1 to 64 Newton steps; the perihelion divide is skipped when the
// input eccentricity is zero.
// One item at a time: each Newton step uses one 31-step CORDIC rotation pass and one
// divide, the final stage a CORDIC pair and the root.
// Reset: clears the sequencer and output valid, sets the threshold to 16, the
// iteration limit to 32 and the stored eccentric anomaly to 0.
module kepler_orbit_position_solver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_semi_major_axis,
  input  logic [30:0] in_eccentricity_in,
  input  logic [31:0] in_mean_longitude,
  input  logic [31:0] in_perihelion_longitude,
  input  logic [31:0] in_node_longitude,
  input  logic signed [31:0] in_axis_correction,
  input  logic signed [31:0] in_eccentricity_correction,
  input  logic signed [31:0] in_longitude_correction,
  input  logic signed [31:0] in_perihelion_correction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_mean_anomaly,
  output logic [31:0] out_perihelion_argument,
  output logic [31:0] out_eccentric_anomaly,
  output logic [31:0] out_radius,
  output logic [31:0] out_true_anomaly,
  output logic [1:0]  out_status
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PDIV  = 5'd1;
  localparam logic [4:0] S_PM    = 5'd2;
  localparam logic [4:0] S_NROT  = 5'd3;
  localparam logic [4:0] S_NROTW = 5'd4;
  localparam logic [4:0] S_NM1   = 5'd5;
  localparam logic [4:0] S_NM2   = 5'd6;
  localparam logic [4:0] S_NM3   = 5'd7;
  localparam logic [4:0] S_NM4   = 5'd8;
  localparam logic [4:0] S_NM5   = 5'd9;
  localparam logic [4:0] S_NM6   = 5'd10;
  localparam logic [4:0] S_NDIV  = 5'd11;
  localparam logic [4:0] S_FROT  = 5'd12;
  localparam logic [4:0] S_FROTW = 5'd13;
  localparam logic [4:0] S_FM1   = 5'd14;
  localparam logic [4:0] S_FM2   = 5'd15;
  localparam logic [4:0] S_FM3   = 5'd16;
  localparam logic [4:0] S_FM4   = 5'd17;
  localparam logic [4:0] S_FM5   = 5'd18;
  localparam logic [4:0] S_FM6   = 5'd19;
  localparam logic [4:0] S_FSQW  = 5'd20;
  localparam logic [4:0] S_FM7   = 5'd21;
  localparam logic [4:0] S_FM8   = 5'd22;
  localparam logic [4:0] S_FVECW = 5'd23;
  localparam logic [4:0] S_OUT   = 5'd24;

  logic [4:0]  state_r;
  logic [20:0] thr_r;
  logic [6:0]  lim_r;
  logic [31:0] last_ecc_r;

  logic [33:0] acorr_r;
  logic [30:0] e_r;
  logic        clamp_r;
  logic        zero_r;
  logic        vneg_r;
  logic [31:0] peri_r;
  logic [31:0] lon_r;
  logic [31:0] node_r;
  logic [31:0] m_r;
  logic [31:0] w_r;
  logic [20:0] thr_run_r;
  logic [6:0]  lim_run_r;
  logic [6:0]  iter_r;
  logic        conv_r;
  logic [31:0] ecc_r;
  logic        fneg_r;
  kops_pkg::dp_t c_r;
  kops_pkg::dp_t s_r;
  kops_pkg::dp_t t_r;
  kops_pkg::dp_t op_a_r;
  kops_pkg::dp_t op_b_r;
  logic signed [71:0] prod_r;
  logic [31:0] r_r;

  logic        out_valid_r;
  logic [31:0] out_m_r;
  logic [31:0] out_w_r;
  logic [31:0] out_ecc_r;
  logic [31:0] out_r_r;
  logic [31:0] out_tv_r;
  logic [1:0]  out_st_r;

  logic        cfg_wr;
  logic        in_fire;
  logic        out_load;

  logic signed [33:0] acorr_sum;
  logic signed [33:0] e_sum;
  logic [31:0]        vk_abs;
  logic [20:0]        thr_eff;
  logic [6:0]         lim_eff;

  kops_pkg::dp_t  e_dp;
  kops_pkg::dp_t  f_val;
  kops_pkg::dp_t  f_abs;
  kops_pkg::dp_t  den;
  kops_pkg::dp_t  d30;
  logic [71:0]    r_sh;
  logic [31:0]    ecc_nxt;
  logic           step_small;

  logic           div_start;
  logic [63:0]    div_dividend;
  logic [34:0]    div_divisor;
  logic           div_busy;
  logic [63:0]    div_q;

  logic           sqrt_start;
  logic [63:0]    sqrt_n;
  logic           sqrt_busy;
  logic [31:0]    sqrt_root;

  logic           cor_start;
  logic           cor_mode;
  kops_pkg::dp_t  cor_x;
  kops_pkg::dp_t  cor_y;
  logic           cor_busy;
  kops_pkg::dp_t  cor_xo;
  kops_pkg::dp_t  cor_yo;
  logic [31:0]    cor_ang;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == kops_pkg::REG_LIMIT) ? {25'b0, lim_r} : {11'b0, thr_r};
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  assign acorr_sum = $signed({2'b0, in_semi_major_axis}) + 34'(in_axis_correction);
  assign e_sum     = $signed({3'b0, in_eccentricity_in}) + 34'(in_eccentricity_correction);
  assign vk_abs    = in_perihelion_correction[31] ? (32'd0 - in_perihelion_correction)
                                                  : in_perihelion_correction;
  assign thr_eff   = (thr_r == '0) ? 21'd1 :
                     (thr_r > kops_pkg::THRESH_MAX) ? kops_pkg::THRESH_MAX : thr_r;
  assign lim_eff   = (lim_r == '0) ? 7'd1 :
                     (lim_r > kops_pkg::LIMIT_MAX) ? kops_pkg::LIMIT_MAX : lim_r;

  assign e_dp   = $signed({5'b0, e_r});
  assign f_val  = kops_pkg::dp_t'($signed(ecc_r - m_r)) - t_r;
  assign f_abs  = f_val[35] ? -f_val : f_val;
  assign den    = 36'sh0_8000_0000 - kops_pkg::dp_t'(prod_r >>> 30);
  assign d30    = 36'sh0_4000_0000 - kops_pkg::dp_t'(prod_r >>> 31);
  assign r_sh   = 72'(prod_r >>> 30);
  assign ecc_nxt    = fneg_r ? (ecc_r + div_q[31:0]) : (ecc_r - div_q[31:0]);
  assign step_small = div_q < {43'b0, thr_run_r};

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {1'b0, vk_abs, 31'b0};
    div_divisor  = {4'b0, in_eccentricity_in};
    if (state_r == S_IDLE) begin
      div_start = in_fire && (in_eccentricity_in != '0);
    end else if (state_r == S_NM6) begin
      div_start    = 1'b1;
      div_dividend = {f_abs[32:0], 31'b0};
      div_divisor  = (den < 36'sd1) ? 35'd1 : den[34:0];
    end
  end

  assign sqrt_start = (state_r == S_FM2);
  assign sqrt_n     = 64'h4000_0000_0000_0000 - prod_r[63:0];

  assign cor_start = (state_r == S_NROT) || (state_r == S_FROT) || (state_r == S_FM8);
  assign cor_mode  = (state_r == S_FM8) ? kops_pkg::MODE_VECTOR : kops_pkg::MODE_ROTATE;
  assign cor_x     = c_r - $signed({6'b0, e_r[30:1]});
  assign cor_y     = kops_pkg::dp_t'(prod_r >>> 31);

  kops_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  kops_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .n_in  (sqrt_n),
    .busy  (sqrt_busy),
    .root  (sqrt_root)
  );

  kops_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .mode    (cor_mode),
    .x_in    (cor_x),
    .y_in    (cor_y),
    .t_in    (ecc_r),
    .busy    (cor_busy),
    .x_out   (cor_xo),
    .y_out   (cor_yo),
    .ang_out (cor_ang)
  );

  always_ff @(posedge clk) begin
    prod_r <= op_a_r * op_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 21'd16;
      lim_r <= 7'd32;
    end else if (cfg_wr) begin
      if (paddr[2] == kops_pkg::REG_THRESH) begin
        thr_r <= pwdata[20:0];
      end else begin
        lim_r <= pwdata[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_ecc_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= (in_eccentricity_in != '0) ? S_PDIV : S_PM;
          end
        end
        S_PDIV:  if (!div_busy) state_r <= S_PM;
        S_PM:    state_r <= S_NROT;
        S_NROT:  state_r <= S_NROTW;
        S_NROTW: if (!cor_busy) state_r <= S_NM1;
        S_NM1:   state_r <= S_NM2;
        S_NM2:   state_r <= S_NM3;
        S_NM3:   state_r <= S_NM4;
        S_NM4:   state_r <= S_NM5;
        S_NM5:   state_r <= S_NM6;
        S_NM6:   state_r <= S_NDIV;
        S_NDIV: begin
          if (!div_busy) begin
            if (step_small || (iter_r + 7'd1 == lim_run_r)) begin
              state_r <= S_FROT;
            end else begin
              state_r <= S_NROT;
            end
          end
        end
        S_FROT: begin
          last_ecc_r <= ecc_r;
          state_r    <= S_FROTW;
        end
        S_FROTW: if (!cor_busy) state_r <= S_FM1;
        S_FM1:   state_r <= S_FM2;
        S_FM2:   state_r <= S_FM3;
        S_FM3:   state_r <= S_FM4;
        S_FM4:   state_r <= S_FM5;
        S_FM5:   state_r <= S_FM6;
        S_FM6:   state_r <= S_FSQW;
        S_FSQW:  if (!sqrt_busy) state_r <= S_FM7;
        S_FM7:   state_r <= S_FM8;
        S_FM8:   state_r <= S_FVECW;
        S_FVECW: if (!cor_busy) state_r <= S_OUT;
        S_OUT:   if (out_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          acorr_r   <= acorr_sum[33] ? 34'd0 : acorr_sum;
          clamp_r   <= e_sum[33] || (e_sum > 34'sh0_7FFF_FFFF);
          e_r       <= e_sum[33] ? 31'd0 :
                       (e_sum > 34'sh0_7FFF_FFFF) ? 31'h7FFF_FFFF : e_sum[30:0];
          zero_r    <= (in_eccentricity_in == '0);
          vneg_r    <= in_perihelion_correction[31];
          peri_r    <= in_perihelion_longitude;
          lon_r     <= in_mean_longitude + in_longitude_correction;
          node_r    <= in_node_longitude;
          thr_run_r <= thr_eff;
          lim_run_r <= lim_eff;
          ecc_r     <= last_ecc_r;
          iter_r    <= '0;
          conv_r    <= 1'b0;
        end
      end
      S_PDIV: begin
        if (!div_busy) begin
          peri_r <= vneg_r ? (peri_r - div_q[31:0]) : (peri_r + div_q[31:0]);
        end
      end
      S_PM: begin
        m_r <= lon_r - peri_r;
        w_r <= peri_r - node_r;
      end
      S_NROTW, S_FROTW: begin
        if (!cor_busy) begin
          c_r    <= cor_xo;
          s_r    <= cor_yo;
          op_a_r <= e_dp;
          op_b_r <= (state_r == S_NROTW) ? cor_yo : e_dp;
        end
      end
      S_NM2: begin
        op_a_r <= kops_pkg::dp_t'(prod_r >>> 30);
        op_b_r <= kops_pkg::TURNS_PER_RAD;
      end
      S_NM4: begin
        t_r    <= kops_pkg::dp_t'(prod_r >>> 31);
        op_a_r <= e_dp;
        op_b_r <= c_r;
      end
      S_NM6: begin
        fneg_r <= f_val[35];
      end
      S_NDIV: begin
        if (!div_busy) begin
          ecc_r  <= ecc_nxt;
          iter_r <= iter_r + 7'd1;
          conv_r <= step_small;
        end
      end
      S_FM2: begin
        op_a_r <= e_dp;
        op_b_r <= c_r;
      end
      S_FM4: begin
        op_a_r <= $signed({2'b0, acorr_r});
        op_b_r <= d30[35] ? 36'sd0 : d30;
      end
      S_FM6: begin
        r_r <= (r_sh[71:32] != '0) ? 32'hFFFF_FFFF : r_sh[31:0];
      end
      S_FSQW: begin
        if (!sqrt_busy) begin
          op_a_r <= $signed({4'b0, sqrt_root});
          op_b_r <= s_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_m_r   <= m_r;
      out_w_r   <= w_r;
      out_ecc_r <= ecc_r;
      out_r_r   <= r_r;
      out_tv_r  <= cor_ang;
      out_st_r  <= clamp_r ? kops_pkg::ST_CLAMP :
                   zero_r  ? kops_pkg::ST_ZERO :
                   conv_r  ? kops_pkg::ST_OK : kops_pkg::ST_NOCONV;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_mean_anomaly        = out_m_r;
  assign out_perihelion_argument = out_w_r;
  assign out_eccentric_anomaly   = out_ecc_r;
  assign out_radius              = out_r_r;
  assign out_true_anomaly        = out_tv_r;
  assign out_status              = out_st_r;

`ifndef SYNTHESIS
  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!div_busy && !sqrt_busy && !cor_busy))
    else $error("unit busy while sequencer idle");

  a_beat_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_OUT))
    else $error("result beat raised outside output state");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NDIV) |-> (iter_r < lim_run_r))
    else $error("Newton step count past limit");
`endif

endmodule
